// File: rtl/projective_envelope_validator_assert.svh
// Assertion macros for the projective envelope validator.
// No dependencies; compiled out when SYNTH is defined.
`ifndef PROJECTIVE_ENVELOPE_VALIDATOR_ASSERT_SVH
`define PROJECTIVE_ENVELOPE_VALIDATOR_ASSERT_SVH
`ifndef SYNTH
`define PEV_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pev assertion failed");
`define PEV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pev assertion failed");
`else
`define PEV_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PEV_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/pev_pkg.sv
`timescale 1ns / 1ps
// Types, codes and bit functions for the projective envelope validator.
// No dependencies.
package pev_pkg;

    localparam logic [31:0] SEED_MUL    = 32'h9E37_79B9;
    localparam logic [15:0] DELTA_CONST = 16'h55AA;
    localparam int          NUM_SLOTS   = 8;

    localparam logic [1:0] STATUS_VALID      = 2'd0;
    localparam logic [1:0] STATUS_UNSAFE     = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH   = 2'd2;
    localparam logic [1:0] STATUS_TRANSITION = 2'd3;

    localparam logic [1:0] HALF_NONE  = 2'd0;
    localparam logic [1:0] HALF_UPPER = 2'd1;
    localparam logic [1:0] HALF_LOWER = 2'd2;

    typedef struct packed {
        logic [7:0]  gauge_slot_0;
        logic [7:0]  gauge_slot_1;
        logic [7:0]  gauge_slot_2;
        logic [7:0]  gauge_slot_3;
        logic [7:0]  gauge_slot_4;
        logic [7:0]  gauge_slot_5;
        logic [7:0]  gauge_slot_6;
        logic [7:0]  gauge_slot_7;
        logic [63:0] expected_kernel_low;
        logic [63:0] expected_kernel_high;
        logic [31:0] car_word;
        logic [31:0] cdr_word;
    } envelope_t;

    typedef struct packed {
        logic [63:0] kernel_low;
        logic [63:0] kernel_high;
        logic [1:0]  status;
        logic [1:0]  forbidden_half;
    } verdict_t;

    // Encoding word of one point; only ever called with constant points.
    function automatic logic [31:0] enc_word(input logic [4:0] pt);
        logic [31:0] seed;
        logic [2:0]  r;
        logic [63:0] dbl;
        seed = {27'd0, pt} * SEED_MUL;
        r    = {2'b00, pt[0]} + {2'b00, pt[1]} + {2'b00, pt[2]}
             + {2'b00, pt[3]} + {2'b00, pt[4]};
        dbl  = {seed, seed} << r;
        return dbl[63:32] ^ (32'd1 << pt);
    endfunction

    function automatic logic [15:0] dlt(input logic [15:0] x);
        return {x[14:0], x[15]} ^ {x[12:0], x[15:13]} ^ {x[1:0], x[15:2]} ^ DELTA_CONST;
    endfunction

    function automatic logic [15:0] fmap(input logic [15:0] x);
        return dlt(x) ^ x;
    endfunction

    function automatic logic sub_unsafe(input logic [15:0] x);
        logic [15:0] fx;
        fx = fmap(x);
        return (fx == 16'd0) || (fmap(fx) == x);
    endfunction

endpackage

// File: rtl/projective_envelope_validator.sv
`timescale 1ns / 1ps
// Projective envelope validator: four-stage elastic pipeline.
// Depends on pev_pkg and projective_envelope_validator_assert.svh.
// An accepted item moves through the stage 0, 1, 2 and 3 registers in order; a stall holds it.
// Throughput: one item per cycle while verdict_ready is high; set by the four pipeline registers.
// Stages: point decode, line parity per point, kernel XOR, checks and status.
// Reset clears every stage valid bit; payload registers are not reset.
`include "projective_envelope_validator_assert.svh"

module projective_envelope_validator (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                envelope_valid,
    output logic                envelope_ready,
    input  pev_pkg::envelope_t  envelope,
    output logic                verdict_valid,
    input  logic                verdict_ready,
    output pev_pkg::verdict_t   verdict
);
    import pev_pkg::*;

    logic         v0_reg, v1_reg, v2_reg, v3_reg;
    logic         en0, en1, en2, en3;

    logic [31:1]  act_next, act0_reg;
    logic [127:0] exp0_reg, exp1_reg, exp2_reg;
    logic [31:0]  car0_reg, cdr0_reg;

    logic [31:1]  par_next, par1_reg;
    logic [1:0]   half_next, half1_reg, half2_reg;

    logic [127:0] kern_next, kern2_reg;

    verdict_t     out_next, out3_reg;

    logic [4:0]   pts [NUM_SLOTS];
    logic [31:0]  act_vec;

    // Elastic handshake: a stage loads when empty or when its successor loads.
    assign en3            = !v3_reg || verdict_ready;
    assign en2            = !v2_reg || en3;
    assign en1            = !v1_reg || en2;
    assign en0            = !v0_reg || en1;
    assign envelope_ready = en0;
    assign verdict_valid  = v3_reg;
    assign verdict        = out3_reg;

    // Stage 0: point set from the gauge bytes
    always_comb
    begin
        pts[0] = envelope.gauge_slot_0[4:0];
        pts[1] = envelope.gauge_slot_1[4:0];
        pts[2] = envelope.gauge_slot_2[4:0];
        pts[3] = envelope.gauge_slot_3[4:0];
        pts[4] = envelope.gauge_slot_4[4:0];
        pts[5] = envelope.gauge_slot_5[4:0];
        pts[6] = envelope.gauge_slot_6[4:0];
        pts[7] = envelope.gauge_slot_7[4:0];
        act_next = '0;
        for (int p = 1; p < 32; p++)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                if (pts[i] == 5'(p))
                begin
                    act_next[p] = 1'b1;
                end
            end
        end
    end

    // Stage 1: a point enters the kernel when an odd number of full lines
    // pass through it; each line through p is taken once, from its smaller q.
    assign act_vec = {act0_reg, 1'b0};

    always_comb
    begin
        logic lines;
        par_next = '0;
        for (int p = 1; p < 32; p++)
        begin
            lines = 1'b0;
            for (int q = 1; q < 32; q++)
            begin
                if (5'(q) < (5'(q) ^ 5'(p)))
                begin
                    lines = lines ^ (act_vec[q] & act_vec[5'(q) ^ 5'(p)]);
                end
            end
            par_next[p] = act_vec[p] & lines;
        end
    end

    always_comb
    begin
        logic [15:0] ch, cl, dh, dl;
        ch = car0_reg[31:16];
        cl = car0_reg[15:0];
        dh = cdr0_reg[31:16];
        dl = cdr0_reg[15:0];
        priority if (dlt(ch) == dh && dlt(dh) == ch)
        begin
            half_next = HALF_UPPER;
        end
        else if (dlt(cl) == dl && dlt(dl) == cl)
        begin
            half_next = HALF_LOWER;
        end
        else
        begin
            half_next = HALF_NONE;
        end
    end

    // Stage 2: kernel as XOR of constant encodings
    always_comb
    begin
        kern_next = '0;
        for (int p = 1; p < 32; p++)
        begin
            if (par1_reg[p])
            begin
                kern_next[(p >> 3) * 32 +: 32] = kern_next[(p >> 3) * 32 +: 32]
                                               ^ enc_word(5'(p));
            end
        end
    end

    // Stage 3: safety over eight subblocks, compare, status priority
    always_comb
    begin
        logic unsafe;
        unsafe = 1'b0;
        for (int s = 0; s < 8; s++)
        begin
            unsafe = unsafe | sub_unsafe(kern2_reg[s * 16 +: 16]);
        end
        out_next.kernel_low     = kern2_reg[63:0];
        out_next.kernel_high    = kern2_reg[127:64];
        out_next.forbidden_half = half2_reg;
        priority if (unsafe)
        begin
            out_next.status = STATUS_UNSAFE;
        end
        else if (kern2_reg != exp2_reg)
        begin
            out_next.status = STATUS_MISMATCH;
        end
        else if (half2_reg != HALF_NONE)
        begin
            out_next.status = STATUS_TRANSITION;
        end
        else
        begin
            out_next.status = STATUS_VALID;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en0) v0_reg <= envelope_valid;
            if (en1) v1_reg <= v0_reg;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            act0_reg <= act_next;
            exp0_reg <= {envelope.expected_kernel_high, envelope.expected_kernel_low};
            car0_reg <= envelope.car_word;
            cdr0_reg <= envelope.cdr_word;
        end
        if (en1)
        begin
            par1_reg  <= par_next;
            exp1_reg  <= exp0_reg;
            half1_reg <= half_next;
        end
        if (en2)
        begin
            kern2_reg <= kern_next;
            exp2_reg  <= exp1_reg;
            half2_reg <= half1_reg;
        end
        if (en3)
        begin
            out3_reg <= out_next;
        end
    end

    `PEV_ASSERT_IMPLIES(a_valid_no_half, clk, rst_n, verdict_valid && verdict.status == STATUS_VALID, verdict.forbidden_half == HALF_NONE)
    `PEV_ASSERT_IMPLIES(a_transition_has_half, clk, rst_n, verdict_valid && verdict.status == STATUS_TRANSITION, verdict.forbidden_half != HALF_NONE)
    `PEV_ASSERT_IMPLIES(a_half_code, clk, rst_n, verdict_valid, verdict.forbidden_half == HALF_NONE || verdict.forbidden_half == HALF_UPPER || verdict.forbidden_half == HALF_LOWER)
    `PEV_ASSERT_IMPLIES(a_stall_only_when_full, clk, rst_n, !envelope_ready, v0_reg && v1_reg && v2_reg && v3_reg && !verdict_ready)
    `PEV_ASSERT_NEXT(a_accept_reaches_s0, clk, rst_n, envelope_valid && envelope_ready, v0_reg)

endmodule
